### rtl/bvss_pkg.sv
// Package for the bencode value span scanner: sizes, mode and status codes, state types.
`timescale 1ns / 1ps
`default_nettype none

package bvss_pkg;

	// Widths of the nesting depth, of the length and byte counters, and of the status and mode codes
	localparam int DEPTH_BITS  = 8;
	localparam int LENGTH_BITS = 32;
	localparam int SPAN_BITS   = 32;
	localparam int STATUS_BITS = 2;
	localparam int MODE_BITS   = 3;

	// Scan modes
	localparam logic [MODE_BITS-1:0] MODE_IDLE   = 3'd0;
	localparam logic [MODE_BITS-1:0] MODE_VALUE  = 3'd1;
	localparam logic [MODE_BITS-1:0] MODE_INT    = 3'd2;
	localparam logic [MODE_BITS-1:0] MODE_DIGITS = 3'd3;
	localparam logic [MODE_BITS-1:0] MODE_SKIP   = 3'd4;

	// Result status codes
	localparam logic [STATUS_BITS-1:0] ST_SCAN  = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_CLOSE = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_BAD   = 2'd2;
	localparam logic [STATUS_BITS-1:0] ST_IDLE  = 2'd3;

	// Bencode token bytes
	localparam logic [7:0] CH_DICT  = 8'h64;	// 'd'
	localparam logic [7:0] CH_LIST  = 8'h6C;	// 'l'
	localparam logic [7:0] CH_INT   = 8'h69;	// 'i'
	localparam logic [7:0] CH_END   = 8'h65;	// 'e'
	localparam logic [7:0] CH_ZERO  = 8'h30;	// '0'
	localparam logic [7:0] CH_NINE  = 8'h39;	// '9'

	localparam logic [DEPTH_BITS-1:0]  DEPTH_MAX = {DEPTH_BITS{1'b1}};
	localparam logic [LENGTH_BITS-1:0] LEN_MAX   = {LENGTH_BITS{1'b1}};

	// Scanner state carried from byte to byte
	typedef struct packed {
		logic [MODE_BITS-1:0]   mode;
		logic [DEPTH_BITS-1:0]  depth;
		logic [LENGTH_BITS-1:0] accum;
		logic [LENGTH_BITS-1:0] skip;
		logic [LENGTH_BITS-1:0] count;
	} scan_state_t;

	// Result of one byte
	typedef struct packed {
		logic [STATUS_BITS-1:0] status;
		logic [SPAN_BITS-1:0]   span_length;
	} scan_result_t;

endpackage

`default_nettype wire

### rtl/bvss_item_if.sv
// Channel interface carrying stream bytes into the scanner.
`timescale 1ns / 1ps
`default_nettype none

interface bvss_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first;
	logic       end_of_file;

	modport source (output valid, output data_byte, output first, output end_of_file,
		input ready);
	modport sink (input valid, input data_byte, input first, input end_of_file,
		output ready);
endinterface

`default_nettype wire

### rtl/bvss_result_if.sv
// Channel interface carrying per-byte scan results out of the scanner.
`timescale 1ns / 1ps
`default_nettype none

interface bvss_result_if;
	import bvss_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [STATUS_BITS-1:0] status;
	logic [SPAN_BITS-1:0]   span_length;

	modport source (output valid, output status, output span_length, input ready);
	modport sink (input valid, input status, input span_length, output ready);
endinterface

`default_nettype wire

### rtl/bvss_step.sv
// Single-byte scan step: next state and result from the current state and one byte.
`timescale 1ns / 1ps
`default_nettype none

module bvss_step (
	input  bvss_pkg::scan_state_t  cur,
	input  logic [7:0]             data_byte,
	input  logic                   first,
	input  logic                   end_of_file,
	output bvss_pkg::scan_state_t  nxt,
	output bvss_pkg::scan_result_t res
);
	import bvss_pkg::*;

	scan_state_t                base;
	logic                       is_digit;
	logic [3:0]                 digit;
	logic [LENGTH_BITS+3:0]     acc_x10;
	logic                       acc_ovf;
	logic                       bad;
	logic                       closed;
	logic                       count_sat;
	logic [LENGTH_BITS-1:0]     skip_dec;
	logic [LENGTH_BITS+SPAN_BITS-1:0] span_ext;

	// Restart clears everything and expects a value
	always_comb begin
		if (first) begin
			base       = '0;
			base.mode  = MODE_VALUE;
		end else begin
			base = cur;
		end
	end

	// Digit decode and the times-ten length update
	assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
	assign digit    = 4'(data_byte - CH_ZERO);
	assign acc_x10  = ({4'd0, base.accum} << 3) + ({4'd0, base.accum} << 1)
		+ {{LENGTH_BITS{1'b0}}, digit};
	assign acc_ovf  = |acc_x10[LENGTH_BITS+3:LENGTH_BITS];

	assign count_sat = (base.count == LEN_MAX);
	assign skip_dec  = (base.skip != '0) ? base.skip - 1'b1 : base.skip;

	// Mode handling
	always_comb begin
		nxt    = base;
		bad    = 1'b0;
		closed = 1'b0;
		res    = '0;
		if ((base.mode == MODE_IDLE) || (base.mode > MODE_SKIP)) begin
			nxt.mode   = MODE_IDLE;
			res.status = ST_IDLE;
		end else begin
			if (count_sat) begin
				bad = 1'b1;
			end else begin
				nxt.count = base.count + 1'b1;
			end
			if (!bad) begin
				case (base.mode)
					MODE_VALUE: begin
						if ((data_byte == CH_DICT) || (data_byte == CH_LIST)) begin
							if (base.depth == DEPTH_MAX) bad = 1'b1;
							else nxt.depth = base.depth + 1'b1;
						end else if (data_byte == CH_INT) begin
							nxt.mode = MODE_INT;
						end else if (is_digit) begin
							nxt.accum = {{(LENGTH_BITS-4){1'b0}}, digit};
							nxt.mode  = MODE_DIGITS;
						end else if (data_byte == CH_END) begin
							if (base.depth == '0) begin
								bad = 1'b1;
							end else begin
								nxt.depth = base.depth - 1'b1;
								closed    = (base.depth == DEPTH_BITS'(1));
							end
						end else begin
							bad = 1'b1;
						end
					end
					MODE_INT: begin
						if (data_byte == CH_END) nxt.mode = MODE_VALUE;
					end
					MODE_DIGITS: begin
						if (is_digit) begin
							if (acc_ovf) bad = 1'b1;
							else nxt.accum = acc_x10[LENGTH_BITS-1:0];
						end else begin
							// terminator byte is consumed unchecked
							nxt.skip  = base.accum;
							nxt.accum = '0;
							nxt.mode  = (base.accum == '0) ? MODE_VALUE : MODE_SKIP;
						end
					end
					default: begin
						nxt.skip = skip_dec;
						if (skip_dec == '0) nxt.mode = MODE_VALUE;
					end
				endcase
			end
			if (!bad && !closed && end_of_file) bad = 1'b1;
			if (bad) begin
				res.status = ST_BAD;
				nxt.mode   = MODE_IDLE;
			end else if (closed) begin
				res.status = ST_CLOSE;
				nxt.mode   = MODE_IDLE;
			end else begin
				res.status = ST_SCAN;
			end
			res.span_length = span_ext[SPAN_BITS-1:0];
		end
	end

	// Span field takes the byte count, zero-extended and cut back to SPAN_BITS
	assign span_ext = {{SPAN_BITS{1'b0}}, nxt.count};

endmodule

`default_nettype wire

### rtl/bencode_value_span_scanner_unit.sv
// Top level of the bencode value span scanner: input register, scan step, result register.
// Usage:
//   Bytes of a bencoded stream enter on the item channel, one per transfer, with
//   first set on the first byte of a value and end_of_file on the last byte of
//   the file. Every accepted byte yields exactly one transfer on the result
//   channel: status (scanning, close, malformed, idle) and span_length, the
//   number of bytes consumed in the span so far.
//   Path: each byte passes the input register and the step logic, and its result
//   is shown from the result register; with result.ready high it then transfers.
//   Throughput: one byte per cycle while the result channel does not stall; the
//   scan state lives in one register updated as the byte leaves the input
//   register, so each byte sees the state left by the byte before it.
//   Stall: while the result register holds an untaken result, the byte in the
//   input register waits and item.ready drops only if that register is full
//   too; nothing is lost or repeated.
//   Reset: arst_n clears both valid flags and puts the scanner in idle mode
//   with zero depth and counters; bytes are ignored (status idle) until one
//   arrives with first set.
`timescale 1ns / 1ps
`default_nettype none

module bencode_value_span_scanner_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	bvss_item_if.sink            item,
	bvss_result_if.source        result
);
	import bvss_pkg::*;

	logic         valid_s1;
	logic [7:0]   data_byte_s1;
	logic         first_s1;
	logic         eof_s1;
	logic         valid_s2;
	scan_result_t result_s2;
	scan_state_t  state_q;
	scan_state_t  state_nxt;
	scan_result_t step_res;
	logic         out_free;
	logic         adv;

	// Stage handshake
	assign out_free   = !valid_s2 || result.ready;
	assign adv        = valid_s1 && out_free;
	assign item.ready = !valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			data_byte_s1 <= item.data_byte;
			first_s1     <= item.first;
			eof_s1       <= item.end_of_file;
		end
	end

	// Scan step
	bvss_step u_step (
		.cur         (state_q),
		.data_byte   (data_byte_s1),
		.first       (first_s1),
		.end_of_file (eof_s1),
		.nxt         (state_nxt),
		.res         (step_res)
	);

	// Scan state; all-zero is idle mode with cleared counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s2 <= step_res;
		end
	end

	assign result.valid       = valid_s2;
	assign result.status      = result_s2.status;
	assign result.span_length = result_s2.span_length;

	// Closing or malformed bytes send the scanner back to idle
	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ((step_res.status == ST_CLOSE) || (step_res.status == ST_BAD))
		|=> (state_q.mode == MODE_IDLE))
		else $error("scanner not idle after close or malformed byte");

	// Skip mode always has bytes left to skip
	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.mode == MODE_SKIP) |-> (state_q.skip != '0))
		else $error("skip mode with zero bytes left");

	// Ignored bytes report an empty span
	a_idle_span: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (result_s2.status == ST_IDLE) |-> (result_s2.span_length == '0))
		else $error("idle result with nonzero span length");

endmodule

`default_nettype wire

### tb/tb_bencode_value_span_scanner_unit.sv
// Testbench for the bencode value span scanner: directed and random byte streams, checked in order.
`timescale 1ns / 1ps

module tb_bencode_value_span_scanner_unit;
	import bvss_pkg::*;

	localparam int ITEM_TARGET  = 1550;
	localparam int MAX_GAP      = 13;
	localparam int QUIET_LIMIT  = 1000;
	localparam int SETTLE_CYCLES = 8;
	localparam int REPORT_MAX   = 10;

	localparam logic [7:0] CH_COLON = 8'h3A;	// ':'
	localparam logic [7:0] CH_MINUS = 8'h2D;	// '-'

	// Tracks the span the way the scanner should and checks its results in order
	class span_scoreboard;
		logic [MODE_BITS-1:0]   mode;
		logic [DEPTH_BITS-1:0]  depth;
		logic [LENGTH_BITS-1:0] accum;
		logic [LENGTH_BITS-1:0] skip;
		logic [LENGTH_BITS-1:0] count;
		scan_result_t           expected_q[$];
		int                     mismatches;

		function new();
			mode       = MODE_IDLE;
			depth      = '0;
			accum      = '0;
			skip       = '0;
			count      = '0;
			mismatches = 0;
		endfunction

		// Predict the result of one accepted byte; returns the predicted status
		function logic [STATUS_BITS-1:0] note_byte(logic [7:0] c, logic f, logic e);
			scan_result_t           res;
			logic                   bad;
			logic                   closed;
			logic                   digit;
			logic [LENGTH_BITS+4:0] grown;
			bad    = 1'b0;
			closed = 1'b0;
			digit  = (c >= CH_ZERO) && (c <= CH_NINE);
			if (f) begin
				mode  = MODE_VALUE;
				depth = '0;
				accum = '0;
				skip  = '0;
				count = '0;
			end
			if (mode == MODE_IDLE || mode > MODE_SKIP) begin
				mode            = MODE_IDLE;
				res.status      = ST_IDLE;
				res.span_length = '0;
			end else begin
				// byte counter saturates and flags the byte past the top
				if (count == LEN_MAX)
					bad = 1'b1;
				else
					count = count + 1'b1;
				if (!bad) begin
					case (mode)
					MODE_VALUE: begin
						if (c == CH_DICT || c == CH_LIST) begin
							if (depth == DEPTH_MAX)
								bad = 1'b1;
							else
								depth = depth + 1'b1;
						end else if (c == CH_INT) begin
							mode = MODE_INT;
						end else if (digit) begin
							accum = LENGTH_BITS'(c - CH_ZERO);
							mode  = MODE_DIGITS;
						end else if (c == CH_END) begin
							if (depth == '0) begin
								bad = 1'b1;
							end else begin
								depth = depth - 1'b1;
								closed = (depth == '0);
							end
						end else begin
							bad = 1'b1;
						end
					end
					MODE_INT: begin
						if (c == CH_END)
							mode = MODE_VALUE;
					end
					MODE_DIGITS: begin
						if (digit) begin
							grown = accum * 10 + (c - CH_ZERO);
							if (grown > LEN_MAX)
								bad = 1'b1;
							else
								accum = LENGTH_BITS'(grown);
						end else begin
							// terminator is consumed whatever it is
							skip  = accum;
							accum = '0;
							mode  = (skip == '0) ? MODE_VALUE : MODE_SKIP;
						end
					end
					default: begin
						if (skip != '0)
							skip = skip - 1'b1;
						if (skip == '0)
							mode = MODE_VALUE;
					end
					endcase
				end
				if (!bad && !closed && e)
					bad = 1'b1;
				if (bad) begin
					res.status = ST_BAD;
					mode       = MODE_IDLE;
				end else if (closed) begin
					res.status = ST_CLOSE;
					mode       = MODE_IDLE;
				end else begin
					res.status = ST_SCAN;
				end
				res.span_length = SPAN_BITS'(count);
			end
			expected_q.push_back(res);
			return res.status;
		endfunction

		// Compare one result transfer with the oldest prediction
		function void check_result(logic [STATUS_BITS-1:0] status,
			logic [SPAN_BITS-1:0] span_length);
			scan_result_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: unexpected result status %0d span %0d", $time,
						status, span_length);
			end else begin
				want = expected_q.pop_front();
				if (status !== want.status || span_length !== want.span_length) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: expected status %0d span %0d, got status %0d span %0d",
							$time, want.status, want.span_length, status, span_length);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	bvss_item_if   item_bus();
	bvss_result_if result_bus();

	bencode_value_span_scanner_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus)
	);

	span_scoreboard span_check = new();
	logic [7:0]     value_bytes[$];
	bit             steady = 1'b0;
	int             scanned = 0;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Drive one byte after a random gap and note it once transferred
	task automatic send_byte(logic [7:0] d, logic f, logic e);
		int gap;
		gap = steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_bus.valid       <= 1'b1;
		item_bus.data_byte   <= d;
		item_bus.first       <= f;
		item_bus.end_of_file <= e;
		do @(posedge clk); while (!item_bus.ready);
		void'(span_check.note_byte(d, f, e));
		scanned++;
	endtask

	// Send the built byte string; first on its opening byte if asked
	task automatic send_stream(bit with_first, bit eof_at_end);
		int  last;
		last = value_bytes.size() - 1;
		foreach (value_bytes[k])
			send_byte(value_bytes[k], with_first && k == 0,
				(eof_at_end && k == last) || $urandom_range(0, 99) == 0);
	endtask

	task automatic send_text(string s, bit eof_at_end);
		value_bytes.delete();
		foreach (s[k])
			value_bytes.push_back(s[k]);
		send_stream(1'b1, eof_at_end);
	endtask

	// Hold the sender until every predicted result has come back
	task automatic wait_results_done();
		item_bus.valid <= 1'b0;
		@(posedge clk);
		while (span_check.expected_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic void emit_number(longint unsigned n);
		string s;
		s = $sformatf("%0d", n);
		foreach (s[k])
			value_bytes.push_back(s[k]);
	endfunction

	// Length-prefixed string, sometimes with leading zeros or an odd terminator
	function automatic void emit_string();
		int len;
		len = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 2)) value_bytes.push_back(CH_ZERO);
		emit_number(len);
		value_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
			: CH_COLON);
		repeat (len) value_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic void emit_value(int lvl, bit nest_only);
		int kind;
		int n;
		if (nest_only)
			kind = $urandom_range(2, 3);
		else
			kind = (lvl >= 4) ? $urandom_range(0, 1) : $urandom_range(0, 3);
		case (kind)
		0: begin
			value_bytes.push_back(CH_INT);
			if ($urandom_range(0, 3) == 0)
				value_bytes.push_back(CH_MINUS);
			repeat ($urandom_range(0, 4))
				value_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
			value_bytes.push_back(CH_END);
		end
		1: begin
			emit_string();
		end
		2: begin
			value_bytes.push_back(CH_LIST);
			n = $urandom_range(0, 4);
			repeat (n) emit_value(lvl + 1, 1'b0);
			value_bytes.push_back(CH_END);
		end
		default: begin
			value_bytes.push_back(CH_DICT);
			n = $urandom_range(0, 3);
			repeat (n) begin
				emit_string();
				emit_value(lvl + 1, 1'b0);
			end
			value_bytes.push_back(CH_END);
		end
		endcase
	endfunction

	// Results: accept with random stalls
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = steady ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				result_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_bus.ready <= 1'b1;
			do @(posedge clk); while (!result_bus.valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready)
			span_check.check_result(result_bus.status, result_bus.span_length);
	end

	// Watchdog: ends the run after a long stretch with no transfer
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	// Stimulus
	initial begin
		int              pick;
		int              n_open;
		bit              paused_mid;
		longint unsigned big;
		paused_mid = 1'b0;
		arst_n               <= 1'b0;
		item_bus.valid       <= 1'b0;
		item_bus.data_byte   <= '0;
		item_bus.first       <= 1'b0;
		item_bus.end_of_file <= 1'b0;
		result_bus.ready     <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// idle before any first: ignored, end of file too
		send_byte(CH_DICT, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b1);
		send_byte(8'hFF, 1'b0, 1'b0);
		// empty list closing with end of file on the close
		send_text("le", 1'b1);
		// stray close at depth zero
		send_text("e", 1'b0);
		// unknown byte where a value is expected
		send_byte(8'hFF, 1'b1, 1'b0);
		// scalars at depth zero and an empty string, then a close
		send_text("i5e0:le", 1'b0);
		// terminator byte is not checked
		send_text("l2Zabe", 1'b0);
		// restart in the middle of a nest
		send_text("ld", 1'b0);
		send_text("l9:", 1'b0);
		send_text("le", 1'b0);
		// end of file before the close
		send_text("li", 1'b1);
		wait_results_done();

		while (scanned < ITEM_TARGET) begin
			if ($urandom_range(0, 7) == 0)
				steady = !steady;
			pick = $urandom_range(0, 99);
			value_bytes.delete();
			if (pick < 2) begin
				// deep nest up to and past the depth limit
				n_open = $urandom_range(250, 256);
				repeat (n_open)
					value_bytes.push_back($urandom_range(0, 1) ? CH_DICT : CH_LIST);
				if (n_open <= int'(DEPTH_MAX) && $urandom_range(0, 1) == 1)
					repeat (n_open) value_bytes.push_back(CH_END);
				else
					repeat ($urandom_range(0, 3)) value_bytes.push_back(CH_END);
				send_stream(1'b1, 1'b0);
			end else if (pick < 6) begin
				// string length around the top of the length range
				big = 64'd4294967290 + $urandom_range(0, 11);
				value_bytes.push_back(CH_LIST);
				emit_number(big);
				if ($urandom_range(0, 3) == 0)
					value_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
				value_bytes.push_back(CH_COLON);
				repeat ($urandom_range(0, 3)) value_bytes.push_back(8'($urandom_range(0, 255)));
				send_stream(1'b1, 1'b0);
			end else if (pick < 14) begin
				// loose bytes, mostly without first
				repeat ($urandom_range(1, 4)) value_bytes.push_back(8'($urandom_range(0, 255)));
				send_stream($urandom_range(0, 3) == 0, $urandom_range(0, 1));
			end else begin
				if ($urandom_range(0, 5) == 0)
					emit_value(4, 1'b0);
				emit_value(1, 1'b1);
				if (pick < 24)
					value_bytes[$urandom_range(0, value_bytes.size() - 1)]
						= 8'($urandom_range(0, 255));
				else if (pick < 34)
					value_bytes = value_bytes[0:$urandom_range(0, value_bytes.size() - 1)];
				send_stream(1'b1, $urandom_range(0, 2) == 0);
			end
			if (!paused_mid && scanned >= ITEM_TARGET / 2) begin
				wait_results_done();
				paused_mid = 1'b1;
			end
		end

		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (span_check.mismatches == 0 && span_check.expected_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
